FILE: rtl/mda_pkg.sv
// shared constants for the morph delta accumulator: field widths, stream
// packing offsets, operation and status codes
// no dependencies
package mda_pkg;

    // field widths
    localparam int INDEX_W      = 12;
    localparam int WEIGHT_W     = 16;
    localparam int COMP_W       = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int VCOUNT_W     = 13;
    localparam int NUM_COMP     = 3;
    localparam int POS_W        = NUM_COMP * COMP_W;

    // weight arithmetic: unsigned q1.15, product of 32 x 17 bits
    localparam int WEIGHT_SHIFT = 15;
    localparam int PROD_W       = COMP_W + WEIGHT_W + 1;
    localparam int SUM_W        = COMP_W + 2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = 16'd0;

    // slave tdata packing, lowest bit up
    localparam int IDX_LSB      = 0;
    localparam int WGT_LSB      = IDX_LSB + INDEX_W;
    localparam int VAL_LSB      = WGT_LSB + WEIGHT_W;
    localparam int S_TDATA_W    = 128;
    localparam int M_TDATA_W    = POS_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELTA = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OOR  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SAT  = 2'd3;

endpackage

FILE: rtl/morph_delta_accumulator.sv
// morph delta accumulator top level: vertex position memory with load,
// weighted delta add and read transfers; uses mda_pkg and mda_lane
// sequence: the memory is read at the input transfer, the lane multiplies,
//   then the add result is written into the output register
// item flow: one item at a time; no new item is taken until the read-multiply-write
//   sequence through the single vertex memory ends, and the add step waits for a free
//   output register; a new item is taken while the previous result still waits in it
// reset: clears the sequencer, the output valid and vertex_count; the
//   vertex memory is not cleared and holds undefined data until loaded
module morph_delta_accumulator #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [mda_pkg::VCOUNT_W-1:0]      cfg_wr_data,  // vertex_count
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vertex_index[11:0], blend_weight[27:12], value_x[59:28],
    // value_y[91:60], value_z[123:92], zero pad[127:124]
    input  logic [mda_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [mda_pkg::OP_W-1:0]          s_tuser,      // operation[1:0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic [mda_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [mda_pkg::STATUS_W-1:0]      m_tuser       // status[1:0]
);
    import mda_pkg::*;

    localparam int DEPTH  = (MAX_VERTICES < (1 << INDEX_W)) ? MAX_VERTICES : (1 << INDEX_W);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMIT_W = 17;
    localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(MAX_VERTICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } state_t;

    state_t                     state_reg;
    logic [VCOUNT_W-1:0]        vcount_reg;
    logic [OP_W-1:0]            op_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [WEIGHT_W-1:0]        weight_reg;
    logic                       valid_idx_reg;
    logic [POS_W-1:0]           val_reg;
    logic [POS_W-1:0]           rd_data_reg;

    logic [POS_W-1:0]           vertex_mem [DEPTH];

    logic                       s_fire;
    logic                       out_free;
    logic [INDEX_W-1:0]         in_index;
    logic [WEIGHT_W-1:0]        in_weight;
    logic [WEIGHT_W-1:0]        weight_next;
    logic                       valid_idx_next;
    logic                       mul_en;
    logic                       mem_wr_en;
    logic [POS_W-1:0]           mem_wr_data;
    logic [POS_W-1:0]           blend_pos;
    logic [NUM_COMP-1:0]        lane_sat;
    logic [POS_W-1:0]           res_pos;
    logic [STATUS_W-1:0]        res_status;

    // input decode
    always_comb begin
        in_index  = s_tdata[IDX_LSB +: INDEX_W];
        in_weight = s_tdata[WGT_LSB +: WEIGHT_W];
        weight_next = (in_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_weight;
        valid_idx_next = ({1'b0, in_index} < vcount_reg) &&
                         (LIMIT_W'(in_index) < LIMIT);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign mul_en   = (state_reg == ST_MUL);

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= '0;
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg        <= s_tuser;
            addr_reg      <= in_index[ADDR_W-1:0];
            weight_reg    <= weight_next;
            valid_idx_reg <= valid_idx_next;
            val_reg       <= s_tdata[VAL_LSB +: POS_W];
        end
    end

    // vertex memory: read on transfer, write back at the end of the item
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            vertex_mem[addr_reg] <= mem_wr_data;
        end
        if (s_fire) begin
            rd_data_reg <= vertex_mem[in_index[ADDR_W-1:0]];
        end
    end

    // blend lanes, one per component
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        mda_lane u_lane (
            .aclk   (aclk),
            .mul_en (mul_en),
            .offset (val_reg[c*COMP_W +: COMP_W]),
            .weight (weight_reg),
            .base   (rd_data_reg[c*COMP_W +: COMP_W]),
            .sum    (blend_pos[c*COMP_W +: COMP_W]),
            .sat    (lane_sat[c])
        );
    end

    // result selection and write back
    always_comb begin
        res_pos     = rd_data_reg;
        res_status  = STAT_OK;
        mem_wr_data = val_reg;
        mem_wr_en   = 1'b0;
        if (!valid_idx_reg) begin
            res_pos    = '0;
            res_status = STAT_OOR;
        end else begin
            case (op_reg)
                OP_LOAD: begin
                    res_pos     = val_reg;
                    mem_wr_data = val_reg;
                    mem_wr_en   = 1'b1;
                end
                OP_DELTA: begin
                    if (weight_reg == WEIGHT_ZERO) begin
                        res_status = STAT_ZERO;
                    end else begin
                        res_pos     = blend_pos;
                        mem_wr_data = blend_pos;
                        mem_wr_en   = 1'b1;
                        res_status  = (lane_sat != '0) ? STAT_SAT : STAT_OK;
                    end
                end
                default: begin
                    res_pos = rd_data_reg;
                end
            endcase
        end
        if (!((state_reg == ST_ADD) && out_free)) begin
            mem_wr_en = 1'b0;
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid  <= 1'b0;
        end else begin
            if (m_tvalid && m_tready && (state_reg != ST_ADD)) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    if (out_free) begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= res_pos;
                        m_tuser   <= res_status;
                        state_reg <= ST_IDLE;
                    end else if (m_tvalid && m_tready) begin
                        m_tvalid <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // one item in flight at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("input taken while an item is in flight");

    // memory is only written for an index inside the vertex count and MAX_VERTICES
    a_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> valid_idx_reg && (state_reg == ST_ADD))
        else $error("vertex memory written for an out of range index");

    // an out of range result carries a zero position
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_OOR)) |-> (m_tdata == '0))
        else $error("out of range result with nonzero position");

    // a new result only follows the add step
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_ADD))
        else $error("result raised outside the add step");

endmodule

FILE: rtl/mda_lane.sv
// one component lane of the blend: registered offset * weight product,
// then round, add to the stored value and clamp to the 32-bit signed range
// depends on mda_pkg
module mda_lane (
    input  logic                                  aclk,
    input  logic                                  mul_en,
    input  logic signed [mda_pkg::COMP_W-1:0]     offset,
    input  logic        [mda_pkg::WEIGHT_W-1:0]   weight,
    input  logic signed [mda_pkg::COMP_W-1:0]     base,
    output logic signed [mda_pkg::COMP_W-1:0]     sum,
    output logic                                  sat
);
    import mda_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (WEIGHT_SHIFT - 1));
    localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] offset_ext;
    logic signed [PROD_W-1:0] weight_ext;
    logic signed [PROD_W-1:0] rounded;
    logic signed [SUM_W-1:0]  wide_sum;

    // product stage
    always_comb begin
        offset_ext = PROD_W'(offset);
        weight_ext = $signed({{(PROD_W-WEIGHT_W){1'b0}}, weight});
        prod_next  = offset_ext * weight_ext;
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // round half up, accumulate and clamp
    always_comb begin
        rounded  = (prod_reg + ROUND_BIAS) >>> WEIGHT_SHIFT;
        wide_sum = SUM_W'(base) + rounded[SUM_W-1:0];
        sat      = (wide_sum[SUM_W-1:COMP_W-1] != {(SUM_W-COMP_W+1){1'b0}}) &&
                   (wide_sum[SUM_W-1:COMP_W-1] != {(SUM_W-COMP_W+1){1'b1}});
        if (sat) begin
            sum = wide_sum[SUM_W-1] ? COMP_MIN : COMP_MAX;
        end else begin
            sum = wide_sum[COMP_W-1:0];
        end
    end

endmodule
